[hw/rtl/ilrs_pkg.sv]
// Shared types and constants for the index linked list reverse/search unit.
`timescale 1ns / 1ps
`default_nettype none
package ilrs_pkg;

  localparam int unsigned KindBits  = 2;
  localparam int unsigned IndexBits = 5;
  localparam int unsigned DataBits  = 16;
  localparam int unsigned LinkBits  = 6;

  localparam logic [KindBits-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KindBits-1:0] KIND_REVERSE = 2'd1;
  localparam logic [KindBits-1:0] KIND_SEARCH  = 2'd2;

  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic [IndexBits-1:0] node_index;
    logic [DataBits-1:0]  node_data;
    logic [LinkBits-1:0]  link_in;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [IndexBits-1:0] position;
  } out_t;

endpackage
`default_nettype wire

[hw/rtl/ilrs_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ilrs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[hw/rtl/index_linked_list_reverse_search_unit.sv]
// Top level: node pool with list reverse and value search sequencer.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one item: write a
//   node (value and link), reverse the list after a head node, or search the
//   list after a start node for a value. Output channel (out_valid_o /
//   out_stall_i / out_data_o) returns exactly one result per item: found and
//   position for a search, zeros otherwise.
//   A write goes straight to the result. A search or reverse visits at most
//   NODES nodes; each visited node takes a read step and a compare or relink
//   step on the single link memory port pair.
//   One item is in work at a time; in_stall_o is high until its result is
//   loaded into the output register. A finished result waits in the output
//   register while out_stall_i is high; the next item is then accepted and
//   run, and its result waits inside until the output register frees up.
//   Reset clears the sequencer and output valid. Node memories are not
//   cleared; reading a node never written returns unspecified data.
//   A link of NODES or more ends a list; every walk stops after NODES links.
`timescale 1ns / 1ps
`default_nettype none
module index_linked_list_reverse_search_unit
  import ilrs_pkg::*;
#(
  parameter int unsigned NODES      = 32,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned IW  = $clog2(NODES);
  localparam int unsigned LWN = $clog2(NODES + 1);
  localparam int unsigned LW  = (LWN > LinkBits) ? LWN : LinkBits;
  localparam int unsigned SW  = $clog2(NODES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_GET,
    S_REV_RD,
    S_REV_WR,
    S_REV_FIX1,
    S_REV_FIX2,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_FINISH
  } state_e;

  state_e                state_q;
  logic [LW-1:0]         cur_q;
  logic [LW-1:0]         prev_q;
  logic [IW-1:0]         first_q;
  logic [IW-1:0]         head_q;
  logic [VALUE_BITS-1:0] want_q;
  logic                  is_rev_q;
  logic [SW-1:0]         steps_q;
  logic                  found_q;
  logic [IndexBits-1:0]  pos_q;
  logic                  out_valid_q;
  out_t                  out_q;

  logic                  accept;
  logic                  idx_ok;
  logic [VALUE_BITS-1:0] data_w;
  logic                  val_we;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  lnk_we;
  logic [IW-1:0]         lnk_waddr;
  logic [LW-1:0]         lnk_wdata;
  logic [LW-1:0]         lnk_rdata;
  logic                  rd_is_node;
  logic                  cur_is_node;
  logic [SW-1:0]         steps_nx;
  logic                  out_free;

  if (VALUE_BITS <= DataBits) begin : g_data_narrow
    assign data_w = in_data_i.node_data[VALUE_BITS-1:0];
  end else begin : g_data_wide
    assign data_w = {{(VALUE_BITS - DataBits){1'b0}}, in_data_i.node_data};
  end

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign idx_ok      = LW'(in_data_i.node_index) < LW'(NODES);
  assign rd_is_node  = lnk_rdata < LW'(NODES);
  assign cur_is_node = cur_q < LW'(NODES);
  assign steps_nx    = steps_q + 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign val_we      = accept && (in_data_i.kind == KIND_WRITE) && idx_ok;

  always_comb begin
    lnk_we    = 1'b0;
    lnk_waddr = cur_q[IW-1:0];
    lnk_wdata = prev_q;
    case (state_q)
      S_IDLE: begin
        lnk_we    = val_we;
        lnk_waddr = IW'(in_data_i.node_index);
        lnk_wdata = LW'(in_data_i.link_in);
      end
      S_REV_WR: begin
        lnk_we = 1'b1;
      end
      S_REV_FIX1: begin
        lnk_we    = 1'b1;
        lnk_waddr = first_q;
        lnk_wdata = LW'(NODES);
      end
      S_REV_FIX2: begin
        lnk_we    = 1'b1;
        lnk_waddr = head_q;
      end
      default: begin
        lnk_we = 1'b0;
      end
    endcase
  end

  ilrs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NODES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (IW'(in_data_i.node_index)),
    .wdata_i (data_w),
    .raddr_i (cur_q[IW-1:0]),
    .rdata_o (val_rdata)
  );

  ilrs_ram #(
    .WIDTH (LW),
    .DEPTH (NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (cur_q[IW-1:0]),
    .rdata_o (lnk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      prev_q      <= '0;
      first_q     <= '0;
      head_q      <= '0;
      want_q      <= '0;
      is_rev_q    <= 1'b0;
      steps_q     <= '0;
      found_q     <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cur_q    <= LW'(in_data_i.node_index);
            head_q   <= IW'(in_data_i.node_index);
            want_q   <= data_w;
            is_rev_q <= (in_data_i.kind == KIND_REVERSE);
            found_q  <= 1'b0;
            pos_q    <= '0;
            if (idx_ok && ((in_data_i.kind == KIND_REVERSE) ||
                           (in_data_i.kind == KIND_SEARCH))) begin
              state_q <= S_HEAD_RD;
            end else begin
              state_q <= S_FINISH;
            end
          end
        end
        S_HEAD_RD: begin
          state_q <= S_HEAD_GET;
        end
        S_HEAD_GET: begin
          cur_q   <= lnk_rdata;
          first_q <= lnk_rdata[IW-1:0];
          prev_q  <= LW'(head_q);
          steps_q <= '0;
          if (!is_rev_q) begin
            state_q <= S_SRCH_RD;
          end else if (rd_is_node) begin
            state_q <= S_REV_RD;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_REV_RD: begin
          state_q <= S_REV_WR;
        end
        S_REV_WR: begin
          prev_q  <= cur_q;
          cur_q   <= lnk_rdata;
          steps_q <= steps_nx;
          if (rd_is_node && (steps_nx < SW'(NODES))) begin
            state_q <= S_REV_RD;
          end else begin
            state_q <= S_REV_FIX1;
          end
        end
        S_REV_FIX1: begin
          state_q <= S_REV_FIX2;
        end
        S_REV_FIX2: begin
          state_q <= S_FINISH;
        end
        S_SRCH_RD: begin
          if (cur_is_node && (steps_q < SW'(NODES))) begin
            state_q <= S_SRCH_CHK;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_SRCH_CHK: begin
          if (val_rdata == want_q) begin
            found_q <= 1'b1;
            pos_q   <= cur_q[IndexBits-1:0];
            state_q <= S_FINISH;
          end else begin
            cur_q   <= lnk_rdata;
            steps_q <= steps_nx;
            state_q <= S_SRCH_RD;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_q.found    <= found_q;
            out_q.position <= pos_q;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[hw/rtl/ilrs_checker.sv]
// Port-level checker for the index linked list reverse/search unit, with bind.
`timescale 1ns / 1ps
`default_nettype none
module ilrs_checker
  import ilrs_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // no hit means zero position
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.position == '0)
    else $error("position nonzero without hit");

  // a transfer in makes the unit busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after input transfer");

  // a new result only comes out of a busy cycle
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in work");

endmodule

bind index_linked_list_reverse_search_unit ilrs_checker u_ilrs_checker (.*);
`default_nettype wire
